>>> hdl/tlc_pkg.sv
// tlc_pkg: types, constants and byte tests shared by the text line classifier
// used by tlc_cell, tlc_chunk and text_line_classifier; no dependencies
`timescale 1ns / 1ps

package tlc_pkg;

  localparam int LEN_W   = 12;
  localparam int COUNT_W = 32;
  localparam int MIN_W   = 7;
  localparam int THR_W   = 4;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON     = 8'h3A;

  localparam logic [MIN_W-1:0] MIN_KEEP_RESET = 7'd5;
  localparam logic [THR_W-1:0] IP_THR_RESET   = 4'd3;
  localparam logic [THR_W-1:0] IP_SAT         = 4'd15;

  localparam logic [LEN_W-1:0] URL_MIN_LEN  = 12'd6;
  localparam logic [LEN_W-1:0] PATH_MIN_LEN = 12'd9;

  // register indexes, taken from paddr[2]
  localparam logic REG_MIN_KEEP = 1'b0;
  localparam logic REG_IP_THR   = 1'b1;

  typedef enum logic [2:0] {
    CLS_SHORT    = 3'd0,
    CLS_URL      = 3'd1,
    CLS_PATH     = 3'd2,
    CLS_IP       = 3'd3,
    CLS_EXE      = 3'd4,
    CLS_WORD     = 3'd5,
    CLS_REPEATED = 3'd6,
    CLS_REJECTED = 3'd7
  } line_class_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
  } cell_t;

  typedef struct packed {
    logic             closing;
    line_class_t      cls;
    logic [LEN_W-1:0] len;
  } chunk_res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_bad(input logic [7:0] c);
    logic ok;
    ok = (c <= 8'h0A) || is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
         ((c >= 8'h61) && (c <= 8'h7A));
    return !ok;
  endfunction

  function automatic logic url_word(input logic [31:0] w);
    return (w == "http") || (w == "Http") || (w == "HTTP") ||
           (w == "www.") || (w == "WWW.");
  endfunction

  function automatic logic exe_word(input logic [31:0] w);
    return (w == ".exe") || (w == ".Exe") || (w == ".EXE") ||
           (w == ".dll") || (w == ".Dll") || (w == ".DLL") ||
           (w == ".sys") || (w == ".Sys") || (w == ".SYS");
  endfunction

endpackage

>>> hdl/tlc_cell.sv
// tlc_cell: one stage of the byte window, holds a byte and its in-chunk mark
// depends on tlc_pkg
`timescale 1ns / 1ps

module tlc_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  logic           clear,
  input  tlc_pkg::cell_t din,
  output tlc_pkg::cell_t dout
);

  tlc_pkg::cell_t held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held.data <= din.data;
    end
    if (rst) begin
      held.valid <= 1'b0;
    end else if (shift) begin
      held.valid <= din.valid & ~clear;
    end
  end

  assign dout = held;

endmodule

>>> hdl/tlc_chunk.sv
// tlc_chunk: chunk length, match flags, ip triple count and class decision
// depends on tlc_pkg; fed by the tlc_cell window
`timescale 1ns / 1ps

module tlc_chunk #(
  parameter int MAX_CHUNK = 1022
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [7:0]                data_byte,
  input  logic                      stream_end,
  input  tlc_pkg::cell_t            c1,
  input  tlc_pkg::cell_t            c2,
  input  tlc_pkg::cell_t            c3,
  input  logic [tlc_pkg::MIN_W-1:0] min_keep_length,
  input  logic [tlc_pkg::THR_W-1:0] ip_dot_threshold,
  output tlc_pkg::chunk_res_t       res
);

  localparam logic [tlc_pkg::LEN_W-1:0] MaxLen = tlc_pkg::LEN_W'(MAX_CHUNK);

  logic [tlc_pkg::LEN_W-1:0] length;
  logic [7:0]                first_byte;
  logic                      f_url, f_path, f_exe, f_bad, f_varied;
  logic [tlc_pkg::THR_W-1:0] ip_triples;

  logic [tlc_pkg::LEN_W-1:0] len;
  logic                      closing;
  logic                      ip_inc;
  logic [tlc_pkg::THR_W-1:0] ip_next;
  logic [31:0]               win;
  logic                      hit_url, hit_path, hit_exe;
  tlc_pkg::line_class_t      cls;

  assign len     = length + 1'b1;
  assign closing = (data_byte == tlc_pkg::CH_NEWLINE) || stream_end || (len >= MaxLen);
  assign win     = {c3.data, c2.data, c1.data, data_byte};

  assign ip_inc  = c2.valid && tlc_pkg::is_digit(c2.data) && (c1.data == tlc_pkg::CH_DOT) &&
                   tlc_pkg::is_digit(data_byte) && (ip_triples != tlc_pkg::IP_SAT);
  assign ip_next = ip_triples + {{(tlc_pkg::THR_W-1){1'b0}}, ip_inc};

  assign hit_url  = (c1.valid && (c1.data == tlc_pkg::CH_SLASH) &&
                     (data_byte == tlc_pkg::CH_SLASH)) ||
                    (c3.valid && tlc_pkg::url_word(win));
  assign hit_path = c1.valid && ((c1.data == tlc_pkg::CH_BACKSLASH) ||
                    (c1.data == tlc_pkg::CH_COLON)) && (data_byte == tlc_pkg::CH_BACKSLASH);
  assign hit_exe  = c3.valid && tlc_pkg::exe_word(win);

  always_comb begin
    if (len <= {{(tlc_pkg::LEN_W-tlc_pkg::MIN_W){1'b0}}, min_keep_length}) begin
      cls = tlc_pkg::CLS_SHORT;
    end else if (f_url && (len >= tlc_pkg::URL_MIN_LEN)) begin
      cls = tlc_pkg::CLS_URL;
    end else if (f_path && (len >= tlc_pkg::PATH_MIN_LEN)) begin
      cls = tlc_pkg::CLS_PATH;
    end else if (ip_next >= ip_dot_threshold) begin
      cls = tlc_pkg::CLS_IP;
    end else if (f_exe) begin
      cls = tlc_pkg::CLS_EXE;
    end else if (!f_bad) begin
      cls = f_varied ? tlc_pkg::CLS_WORD : tlc_pkg::CLS_REPEATED;
    end else begin
      cls = tlc_pkg::CLS_REJECTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length     <= '0;
      first_byte <= '0;
      f_url      <= 1'b0;
      f_path     <= 1'b0;
      f_exe      <= 1'b0;
      f_bad      <= 1'b0;
      f_varied   <= 1'b0;
      ip_triples <= '0;
    end else if (step) begin
      if (closing) begin
        length     <= '0;
        first_byte <= '0;
        f_url      <= 1'b0;
        f_path     <= 1'b0;
        f_exe      <= 1'b0;
        f_bad      <= 1'b0;
        f_varied   <= 1'b0;
        ip_triples <= '0;
      end else begin
        length     <= len;
        ip_triples <= ip_next;
        f_url      <= f_url | hit_url;
        f_path     <= f_path | hit_path;
        f_exe      <= f_exe | hit_exe;
        f_bad      <= f_bad | tlc_pkg::is_bad(data_byte);
        if (length == '0) begin
          first_byte <= data_byte;
        end else if (data_byte != first_byte) begin
          f_varied <= 1'b1;
        end
      end
    end
  end

  assign res.closing = closing;
  assign res.cls     = cls;
  assign res.len     = len;

endmodule

>>> hdl/text_line_classifier.sv
// text_line_classifier: top level, byte window of tlc_cell stages, tlc_chunk,
// config registers and output register; depends on tlc_pkg
`timescale 1ns / 1ps

// usage
// - s_* channel takes one text byte per request, s_tlast marks the end of the
//   stream and closes the current chunk
// - a chunk also closes on a newline byte or when it reaches MAX_CHUNK bytes
// - m_* channel gives one request per closed chunk: class, length (closing
//   byte included) and the running count of kept chunks
// - registers over apb: 0x0 min_keep_length, 0x4 ip_dot_threshold; write only
//   while the stream is idle
// - throughput one byte per cycle while the output is not stalled; a byte passes
//   the three-stage window and the chunk logic in the cycle it is accepted
// - the result is registered: it shows on m_tvalid the cycle after the
//   closing byte is accepted
// - while m_tvalid is high and m_tready low, s_tready drops and the result
//   holds; with m_tready high a new byte is taken in the same cycle
// - reset clears the window, chunk state, kept count and output register and
//   loads the register defaults; no clearing pass

module text_line_classifier #(
  parameter int MAX_CHUNK = 1022
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // data_byte
  input  logic                        s_tlast,   // stream_end
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [47:0]                 m_tdata,   // line_class, line_length, kept_count, pad
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tlc_pkg::DATA_W-1:0]  pwdata,
  output logic [tlc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic [tlc_pkg::MIN_W-1:0]   min_keep_length;
  logic [tlc_pkg::THR_W-1:0]   ip_dot_threshold;
  logic [tlc_pkg::COUNT_W-1:0] kept_total;
  logic [tlc_pkg::COUNT_W-1:0] kept_total_next;

  logic                        out_valid;
  tlc_pkg::line_class_t        out_class;
  logic [tlc_pkg::LEN_W-1:0]   out_length;
  logic [tlc_pkg::COUNT_W-1:0] out_count;

  logic                        accept;
  logic                        kept;
  tlc_pkg::cell_t              chain [0:3];
  tlc_pkg::chunk_res_t         res;

  assign pready   = 1'b1;
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_keep_length  <= tlc_pkg::MIN_KEEP_RESET;
      ip_dot_threshold <= tlc_pkg::IP_THR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        tlc_pkg::REG_MIN_KEEP: min_keep_length  <= pwdata[tlc_pkg::MIN_W-1:0];
        tlc_pkg::REG_IP_THR:   ip_dot_threshold <= pwdata[tlc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tlc_pkg::REG_MIN_KEEP:
        prdata = {{(tlc_pkg::DATA_W-tlc_pkg::MIN_W){1'b0}}, min_keep_length};
      tlc_pkg::REG_IP_THR:
        prdata = {{(tlc_pkg::DATA_W-tlc_pkg::THR_W){1'b0}}, ip_dot_threshold};
      default:
        prdata = '0;
    endcase
  end

  // byte window
  assign chain[0] = '{data: s_tdata, valid: 1'b1};

  for (genvar i = 0; i < 3; i++) begin : g_cell
    tlc_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (accept),
      .clear (res.closing),
      .din   (chain[i]),
      .dout  (chain[i+1])
    );
  end

  tlc_chunk #(
    .MAX_CHUNK (MAX_CHUNK)
  ) u_chunk (
    .clk              (clk),
    .rst              (rst),
    .step             (accept),
    .data_byte        (s_tdata),
    .stream_end       (s_tlast),
    .c1               (chain[1]),
    .c2               (chain[2]),
    .c3               (chain[3]),
    .min_keep_length  (min_keep_length),
    .ip_dot_threshold (ip_dot_threshold),
    .res              (res)
  );

  assign kept = (res.cls != tlc_pkg::CLS_SHORT) && (res.cls != tlc_pkg::CLS_REJECTED);
  assign kept_total_next = kept_total + {{(tlc_pkg::COUNT_W-1){1'b0}}, kept};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      kept_total <= '0;
    end else if (accept && res.closing) begin
      out_valid  <= 1'b1;
      kept_total <= kept_total_next;
    end else if (m_tready) begin
      out_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.closing) begin
      out_class  <= res.cls;
      out_length <= res.len;
      out_count  <= kept_total_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_count, out_length, out_class};

endmodule
